// ===== sv/ibm_pkg.sv =====
package ibm_pkg;

  // Command codes carried in the mode field.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_SEND  = 3'd2;
  localparam logic [2:0] MODE_ACK   = 3'd3;
  localparam logic [2:0] MODE_GET   = 3'd4;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
  localparam logic [2:0] LAST_BIT          = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_ACK   = 3'd4,
    OP_GET   = 3'd5
  } op_e;

  // One tick as presented to the sequencer.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } ibm_item_t;

  // Pin and status levels after one tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_seen;
  } ibm_result_t;

endpackage

// ===== sv/ibm_seq.sv =====
module ibm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           phase_ticks_i,
  input  ibm_pkg::ibm_item_t   item_i,
  output ibm_pkg::ibm_result_t result_o
);
  import ibm_pkg::*;

  op_e        op_q, op_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drive_q, drive_d;
  logic       done;
  logic [7:0] period;

  assign period = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;

  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drive_d = drive_q;
    done    = 1'b0;

    if (op_q == OP_IDLE) begin
      if (item_i.cmd_valid && (item_i.mode inside {[MODE_START:MODE_GET]})) begin
        phase_d = 2'd0;
        bit_d   = 3'd0;
        shift_d = 8'd0;
        tick_d  = 8'd1;
        case (item_i.mode)
          MODE_START: begin
            op_d = OP_START; scl_d = 1'b1; sda_d = 1'b1; drive_d = 1'b1;
          end
          MODE_STOP: begin
            op_d = OP_STOP; drive_d = 1'b1; sda_d = 1'b0;
          end
          MODE_SEND: begin
            op_d = OP_SEND; shift_d = item_i.tx_byte;
            drive_d = 1'b1; scl_d = 1'b0; sda_d = item_i.tx_byte[7];
          end
          MODE_ACK: begin
            op_d = OP_ACK; drive_d = 1'b0; scl_d = 1'b0;
          end
          default: begin
            op_d = OP_GET; drive_d = 1'b0; scl_d = 1'b1;
          end
        endcase
      end
    end else if (tick_q < period) begin
      tick_d = tick_q + 8'd1;
    end else begin
      // End of the current phase: enter the next phase or complete.
      tick_d = 8'd1;
      case (op_q)
        OP_START: begin
          if (phase_q == 2'd0) begin
            phase_d = 2'd1; sda_d = 1'b0;
          end else if (phase_q == 2'd1) begin
            phase_d = 2'd2; scl_d = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_q == 2'd0) begin
            phase_d = 2'd1; scl_d = 1'b1;
          end else if (phase_q == 2'd1) begin
            phase_d = 2'd2; sda_d = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        OP_SEND: begin
          if (phase_q == 2'd0) begin
            phase_d = 2'd1; scl_d = 1'b1;
          end else if (phase_q == 2'd1) begin
            phase_d = 2'd2; scl_d = 1'b0;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            if (bit_q != LAST_BIT) begin
              bit_d   = bit_q + 3'd1;
              phase_d = 2'd0;
              drive_d = 1'b1;
              scl_d   = 1'b0;
              sda_d   = shift_q[6];
            end else begin
              drive_d = 1'b0;
              done    = 1'b1;
            end
          end
        end
        OP_ACK: begin
          if (phase_q == 2'd0) begin
            phase_d = 2'd1; scl_d = 1'b1;
          end else if (phase_q == 2'd1) begin
            ack_d = ~item_i.sda_in; phase_d = 2'd2; scl_d = 1'b0;
          end else begin
            drive_d = 1'b1;
            done    = 1'b1;
          end
        end
        OP_GET: begin
          if (phase_q == 2'd0) begin
            shift_d = {shift_q[6:0], item_i.sda_in};
            phase_d = 2'd1;
            scl_d   = 1'b0;
          end else if (bit_q != LAST_BIT) begin
            bit_d   = bit_q + 3'd1;
            phase_d = 2'd0;
            drive_d = 1'b0;
            scl_d   = 1'b1;
          end else begin
            rx_d = shift_q;
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        op_d    = OP_IDLE;
        phase_d = 2'd0;
        tick_d  = 8'd0;
        bit_d   = 3'd0;
      end
    end
  end

  always_comb begin
    result_o.scl_level = scl_d;
    result_o.sda_level = drive_d ? sda_d : 1'b1;
    result_o.sda_drive = drive_d;
    result_o.busy_res  = (op_d != OP_IDLE);
    result_o.done_res  = done;
    result_o.rx_data   = rx_d;
    result_o.ack_seen  = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      phase_q <= 2'd0;
      tick_q  <= 8'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      rx_q    <= 8'd0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drive_q <= 1'b1;
    end else if (step_i) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drive_q <= drive_d;
    end
  end

endmodule

// ===== sv/i2c_bit_level_master_unit.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  cmd_valid_i mode_i tx_byte_i sda_in_i
// out       output     out_valid_o/out_stall_i scl_level_o sda_level_o sda_drive_o
//                                             busy_res_o done_res_o rx_data_o ack_seen_o
// cfg       input      cfg_we_i               cfg_wdata_i (phase_ticks)
//
// Each input transaction is one bus tick and yields exactly one output transaction.
// A transaction passes through the input register and then leaves through the output
// register; one transaction is taken per cycle while the output does not stall.
// Reset puts the sequencer in the idle state (SCL and SDA high, SDA driven) with phase_ticks 2.
// A stall on the output holds both registers; the input stalls only when its register
// is full and the output register cannot move.
module i2c_bit_level_master_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_valid_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       sda_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_data_o,
  output logic       ack_seen_o
);
  import ibm_pkg::*;

  logic        [7:0] phase_ticks_q;
  logic              in_valid_q;
  ibm_item_t         item_q;
  logic              out_valid_q;
  ibm_result_t       result_q;
  ibm_result_t       result_d;
  logic              advance;
  logic              step;

  // The output register can take a new transaction when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RESET;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.cmd_valid <= cmd_valid_i;
      item_q.mode      <= mode_i;
      item_q.tx_byte   <= tx_byte_i;
      item_q.sda_in    <= sda_in_i;
    end
  end

  // The sequencer updates its state only when the tick moves to the output register.
  ibm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .phase_ticks_i (phase_ticks_q),
    .item_i        (item_q),
    .result_o      (result_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = result_q.scl_level;
  assign sda_level_o = result_q.sda_level;
  assign sda_drive_o = result_q.sda_drive;
  assign busy_res_o  = result_q.busy_res;
  assign done_res_o  = result_q.done_res;
  assign rx_data_o   = result_q.rx_data;
  assign ack_seen_o  = result_q.ack_seen;

endmodule
